>>> design/lxyz_pkg.sv
`default_nettype none
package lxyz_pkg;

  localparam int BLOCKS_PER_PACKET = 12;
  localparam int MAX_LASERS        = 32;
  localparam int LASER_W           = $clog2(MAX_LASERS);

  localparam logic [27:0] RAD_K         = 28'd191900981;
  localparam logic [9:0]  NS_PER_US     = 10'd1000;
  localparam logic [15:0] STRIDE_NS     = 16'd55296;
  localparam logic [19:0] PKT_STRIDE_NS = 20'(BLOCKS_PER_PACKET * 55296);
  localparam logic [15:0] DEG_360       = 16'd36000;
  localparam logic [15:0] DEG_90        = 16'd9000;
  localparam logic [15:0] DEG_180       = 16'd18000;
  localparam logic [15:0] DEG_270       = 16'd27000;
  localparam logic [13:0] DEG_45        = 14'd4500;
  localparam logic [30:0] Q_ONE         = 31'h4000_0000;
  localparam logic [19:0] POS_LIMIT     = 20'd524280;

  // Horner divisors and their reciprocals scaled by 2^31
  localparam int NSTEP = 5;
  localparam int NSIN  = 4;
  localparam logic [6:0]  KC [NSTEP] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
  localparam logic [6:0]  KS [NSIN]  = '{7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [30:0] MC [NSTEP] = '{
    31'((64'd1 << 31) / 64'd90), 31'((64'd1 << 31) / 64'd56),
    31'((64'd1 << 31) / 64'd30), 31'((64'd1 << 31) / 64'd12),
    31'((64'd1 << 31) / 64'd2)};
  localparam logic [30:0] MS [NSIN] = '{
    31'((64'd1 << 31) / 64'd72), 31'((64'd1 << 31) / 64'd42),
    31'((64'd1 << 31) / 64'd20), 31'((64'd1 << 31) / 64'd6)};

  // angle reduce, x, x^2, horner steps, quadrant map
  localparam int TRIG_LAT = 3 + 3 * NSTEP + 1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic {
    OP_CONVERT = 1'b0,
    OP_WRITE   = 1'b1
  } op_e;

  typedef struct packed {
    logic [15:0] az;
    logic [15:0] va;
    logic [15:0] range_raw;
    logic [7:0]  inten;
    logic [31:0] tus;
    logic [3:0]  blk;
    logic [11:0] pkt;
  } item_t;

  typedef struct packed {
    logic [19:0] x;
    logic [19:0] y;
    logic [19:0] z;
    logic [7:0]  inten;
    logic [41:0] ts;
  } point_t;

endpackage
`default_nettype wire

>>> design/lxyz_fifo.sv
`default_nettype none
module lxyz_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lxyz_pkg::item_t     item_i,
  output logic                ready_o,
  input  logic                pop_i,
  output lxyz_pkg::item_t     item_o,
  output logic                valid_o
);

  lxyz_pkg::item_t                mem_q [lxyz_pkg::FIFO_DEPTH];
  logic [lxyz_pkg::FIFO_AW-1:0]   wp_q, rp_q;
  logic [lxyz_pkg::FIFO_AW:0]     cnt_q;

  assign ready_o = cnt_q != (lxyz_pkg::FIFO_AW+1)'(lxyz_pkg::FIFO_DEPTH);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= rp_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/lxyz_front.sv
`default_nettype none
module lxyz_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [5:0]        cfg_wdata_i,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic [111:0]      s_data_i,
  input  logic              s_user_i,
  output lxyz_pkg::item_t   item_o,
  output logic              item_valid_o,
  input  logic              item_ready_i
);

  logic [5:0]                    lc_q;
  logic signed [14:0]            vtab_q [lxyz_pkg::MAX_LASERS];
  logic                          fv_q, fv_d;
  lxyz_pkg::item_t               item_q, item_d;
  lxyz_pkg::op_e                 op;
  logic                          acc, conv;
  logic [4:0]                    ch;
  logic [15:0]                   az, range_raw;
  logic signed [14:0]            va_in, vt;
  logic [5:0]                    rem;
  logic [10:0]                   dv;
  logic [lxyz_pkg::LASER_W-1:0]  laser;
  logic signed [16:0]            vs;

  assign op        = lxyz_pkg::op_e'(s_user_i);
  assign ch        = s_data_i[20:16];
  assign az        = s_data_i[36:21];
  assign range_raw = s_data_i[52:37];
  assign va_in     = s_data_i[107:93];

  assign s_ready_o    = !fv_q || item_ready_i;
  assign acc          = s_valid_i && s_ready_o;
  assign conv         = acc && (op == lxyz_pkg::OP_CONVERT) && (range_raw != '0);
  assign item_o       = item_q;
  assign item_valid_o = fv_q;

  // channel modulo laser count, restoring subtract
  always_comb begin
    rem = {1'b0, ch};
    dv  = '0;
    for (int k = 4; k >= 0; k--) begin
      dv = 11'(lc_q) << k;
      if (11'(rem) >= dv) begin
        rem = 6'(11'(rem) - dv);
      end
    end
    laser = (lc_q == '0) ? '0 : rem[lxyz_pkg::LASER_W-1:0];
  end

  always_comb begin
    vt = vtab_q[laser];
    vs = 17'(vt) + ((vt < 0) ? 17'sd36000 : 17'sd0);
    item_d.az        = (az >= lxyz_pkg::DEG_360) ? (az - lxyz_pkg::DEG_360) : az;
    item_d.va        = vs[15:0];
    item_d.range_raw = range_raw;
    item_d.inten     = s_data_i[60:53];
    item_d.tus       = s_data_i[92:61];
    item_d.blk       = s_data_i[15:12];
    item_d.pkt       = s_data_i[11:0];
  end

  always_comb begin
    fv_d = fv_q;
    if (conv) begin
      fv_d = 1'b1;
    end else if (acc) begin
      fv_d = 1'b0;
    end else if (item_ready_i) begin
      fv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && op == lxyz_pkg::OP_WRITE) begin
      vtab_q[ch[lxyz_pkg::LASER_W-1:0]] <= va_in;
    end
    if (conv) begin
      item_q <= item_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_q <= 6'd16;
      fv_q <= 1'b0;
    end else begin
      fv_q <= fv_d;
      if (cfg_we_i) begin
        lc_q <= cfg_wdata_i;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/lxyz_trig.sv
`default_nettype none
module lxyz_trig (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [15:0]        ang_i,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  typedef struct packed {
    logic [29:0] x;
    logic [29:0] x2;
    logic [1:0]  quad;
    logic        flip;
  } car_t;

  localparam int NS = lxyz_pkg::NSTEP;

  logic [1:0]   quad;
  logic [13:0]  r;
  logic [12:0]  rr_q;
  logic [1:0]   quad0_q, quad1_q;
  logic         flip0_q, flip1_q;
  logic [29:0]  x_q;
  logic [40:0]  xf;
  logic [59:0]  x2f;

  car_t         car_q  [NS+1];
  car_t         cara_q [NS];
  car_t         carb_q [NS];
  logic [30:0]  us_q   [NS+1];
  logic [30:0]  uc_q   [NS+1];
  logic [30:0]  nas_q  [NS];
  logic [30:0]  nac_q  [NS];
  logic [30:0]  nbs_q  [NS];
  logic [30:0]  nbc_q  [NS];
  logic [30:0]  qbs_q  [NS];
  logic [30:0]  qbc_q  [NS];

  logic [30:0]  s0, c0, sv, cv;

  always_comb begin
    if (ang_i < lxyz_pkg::DEG_90) begin
      quad = 2'd0;
      r    = 14'(ang_i);
    end else if (ang_i < lxyz_pkg::DEG_180) begin
      quad = 2'd1;
      r    = 14'(ang_i - lxyz_pkg::DEG_90);
    end else if (ang_i < lxyz_pkg::DEG_270) begin
      quad = 2'd2;
      r    = 14'(ang_i - lxyz_pkg::DEG_180);
    end else begin
      quad = 2'd3;
      r    = 14'(ang_i - lxyz_pkg::DEG_270);
    end
  end

  assign xf  = 41'(rr_q) * 41'(lxyz_pkg::RAD_K) + 41'd512;
  assign x2f = 60'(x_q) * 60'(x_q) + (60'd1 << 29);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flip0_q        <= r > lxyz_pkg::DEG_45;
      rr_q           <= (r > lxyz_pkg::DEG_45) ? 13'(14'(lxyz_pkg::DEG_90) - r) : 13'(r);
      quad0_q        <= quad;
      x_q            <= xf[39:10];
      quad1_q        <= quad0_q;
      flip1_q        <= flip0_q;
      car_q[0].x     <= x_q;
      car_q[0].x2    <= x2f[59:30];
      car_q[0].quad  <= quad1_q;
      car_q[0].flip  <= flip1_q;
      us_q[0]        <= lxyz_pkg::Q_ONE;
      uc_q[0]        <= lxyz_pkg::Q_ONE;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_step
    logic [60:0] pc, ps;
    logic [61:0] rc, rs;
    logic [31:0] remc, rems;

    assign pc   = 61'(car_q[i].x2) * 61'(uc_q[i]);
    assign rc   = 62'(nac_q[i]) * 62'(lxyz_pkg::MC[i]);
    assign remc = 32'(nbc_q[i]) - 32'(qbc_q[i]) * 32'(lxyz_pkg::KC[i]);

    if (i < lxyz_pkg::NSIN) begin : g_sin
      assign ps   = 61'(car_q[i].x2) * 61'(us_q[i]);
      assign rs   = 62'(nas_q[i]) * 62'(lxyz_pkg::MS[i]);
      assign rems = 32'(nbs_q[i]) - 32'(qbs_q[i]) * 32'(lxyz_pkg::KS[i]);
    end else begin : g_fin
      assign ps   = 61'(car_q[i].x) * 61'(us_q[i]);
      assign rs   = '0;
      assign rems = '0;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cara_q[i]  <= car_q[i];
        nac_q[i]   <= pc[60:30];
        nas_q[i]   <= ps[60:30];
        carb_q[i]  <= cara_q[i];
        nbc_q[i]   <= nac_q[i];
        nbs_q[i]   <= nas_q[i];
        qbc_q[i]   <= rc[61:31];
        qbs_q[i]   <= rs[61:31];
        car_q[i+1] <= carb_q[i];
        uc_q[i+1]  <= lxyz_pkg::Q_ONE - (qbc_q[i]
                      + 31'(remc >= 32'(lxyz_pkg::KC[i])));
        if (i < lxyz_pkg::NSIN) begin
          us_q[i+1] <= lxyz_pkg::Q_ONE - (qbs_q[i]
                       + 31'(rems >= 32'(lxyz_pkg::KS[i % lxyz_pkg::NSIN])));
        end else begin
          us_q[i+1] <= nbs_q[i];
        end
      end
    end
  end

  always_comb begin
    s0 = (us_q[NS] > lxyz_pkg::Q_ONE) ? lxyz_pkg::Q_ONE : us_q[NS];
    c0 = (uc_q[NS] > lxyz_pkg::Q_ONE) ? lxyz_pkg::Q_ONE : uc_q[NS];
    sv = car_q[NS].flip ? c0 : s0;
    cv = car_q[NS].flip ? s0 : c0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (car_q[NS].quad)
        2'd0: begin
          sin_o <= 32'(sv);
          cos_o <= 32'(cv);
        end
        2'd1: begin
          sin_o <= 32'(cv);
          cos_o <= -32'(sv);
        end
        2'd2: begin
          sin_o <= -32'(sv);
          cos_o <= -32'(cv);
        end
        default: begin
          sin_o <= -32'(cv);
          cos_o <= 32'(sv);
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> design/lxyz_back.sv
`default_nettype none
module lxyz_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lxyz_pkg::item_t   item_i,
  input  logic              item_valid_i,
  output logic              pop_o,
  output lxyz_pkg::point_t  point_o,
  output logic              valid_o,
  input  logic              ready_i
);

  localparam int TL = lxyz_pkg::TRIG_LAT;

  typedef struct packed {
    logic [18:0] d8;
    logic [7:0]  inten;
    logic [41:0] ts;
  } side_t;

  logic                 en;
  logic [TL:0]          vld_q;
  logic                 out_v_q;
  side_t                side_q [TL];
  side_t                p1side_q;
  logic [33:0]          off_q;
  logic signed [31:0]   sa, ca, sv, cv;
  logic [30:0]          pxm_q, pym_q, pzm_q;
  logic                 pxn_q, pyn_q, pzn_q;
  lxyz_pkg::point_t     out_q;

  function automatic logic [30:0] mag(input logic signed [31:0] v);
    logic signed [31:0] a;
    a = (v < 0) ? -v : v;
    return a[30:0];
  endfunction

  function automatic logic [30:0] qmul(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] p;
    p = 62'(a) * 62'(b) + (62'd1 << 29);
    return p[60:30];
  endfunction

  function automatic logic [19:0] coord(input logic [18:0] d8, input logic [30:0] pm,
                                        input logic neg);
    logic [49:0] p;
    logic [19:0] m;
    p = 50'(d8) * 50'(pm) + (50'd1 << 29);
    m = (p[49:30] > lxyz_pkg::POS_LIMIT) ? lxyz_pkg::POS_LIMIT : p[49:30];
    return neg ? -m : m;
  endfunction

  assign en      = !out_v_q || ready_i;
  assign pop_o   = en && item_valid_i;
  assign valid_o = out_v_q;
  assign point_o = out_q;

  lxyz_trig u_trig_az (
    .clk_i (clk_i),
    .en_i  (en),
    .ang_i (item_i.az),
    .sin_o (sa),
    .cos_o (ca)
  );

  lxyz_trig u_trig_vert (
    .clk_i (clk_i),
    .en_i  (en),
    .ang_i (item_i.va),
    .sin_o (sv),
    .cos_o (cv)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0].d8    <= {item_i.range_raw, 3'b000};
      side_q[0].inten <= item_i.inten;
      side_q[0].ts    <= 42'(item_i.tus) * 42'(lxyz_pkg::NS_PER_US);
      off_q           <= 34'(item_i.blk) * 34'(lxyz_pkg::STRIDE_NS)
                         + 34'(item_i.pkt) * 34'(lxyz_pkg::PKT_STRIDE_NS);
      side_q[1].d8    <= side_q[0].d8;
      side_q[1].inten <= side_q[0].inten;
      side_q[1].ts    <= side_q[0].ts + 42'(off_q);
      for (int i = 2; i < TL; i++) begin
        side_q[i] <= side_q[i-1];
      end
      p1side_q <= side_q[TL-1];
      pxm_q    <= qmul(mag(cv), mag(sa));
      pxn_q    <= (cv < 0) != (sa < 0);
      pym_q    <= qmul(mag(cv), mag(ca));
      pyn_q    <= (cv < 0) != (ca < 0);
      pzm_q    <= mag(sv);
      pzn_q    <= sv < 0;
      out_q.x     <= coord(p1side_q.d8, pxm_q, pxn_q);
      out_q.y     <= coord(p1side_q.d8, pym_q, pyn_q);
      out_q.z     <= coord(p1side_q.d8, pzm_q, pzn_q);
      out_q.inten <= p1side_q.inten;
      out_q.ts    <= p1side_q.ts;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      vld_q   <= {vld_q[TL-1:0], item_valid_i};
      out_v_q <= vld_q[TL];
    end
  end

endmodule
`default_nettype wire

>>> design/lidar_return_to_xyz.sv
// From an input transfer to its output transfer an item passes the front
// register, the queue, the 19-stage sine/cosine pipeline, the product
// stage and the coordinate stage with output register.
// Throughput: one item per cycle unless stalled; table writes give no output.
// Reset: control cleared, laser count 16; angle table undefined until written.
`default_nettype none
module lidar_return_to_xyz (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [5:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // packet number, block_index, channel_index, azimuth, distance_raw,
  // intensity, packet_time_us, vertical_angle
  input  logic [111:0] s_axis_tdata,
  // operation
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // x_pos, y_pos, z_pos, point_intensity, timestamp_ns
  output logic [111:0] m_axis_tdata
);

  lxyz_pkg::item_t   f_item, q_item;
  logic              f_valid, q_ready, q_valid, q_pop;
  lxyz_pkg::point_t  pt;

  lxyz_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .s_user_i     (s_axis_tuser),
    .item_o       (f_item),
    .item_valid_o (f_valid),
    .item_ready_i (q_ready)
  );

  lxyz_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid && q_ready),
    .item_i  (f_item),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .item_o  (q_item),
    .valid_o (q_valid)
  );

  lxyz_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (q_item),
    .item_valid_i (q_valid),
    .pop_o        (q_pop),
    .point_o      (pt),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready)
  );

  assign m_axis_tdata = {2'b00, pt.ts, pt.inten, pt.z, pt.y, pt.x};

endmodule
`default_nettype wire

>>> test/tb_top.sv
`default_nettype none
module tb_top;
  import lxyz_pkg::*;

  typedef struct {
    op_e              op;
    logic [11:0]      pkt;
    logic [3:0]       blk;
    logic [4:0]       ch;
    logic [15:0]      az;
    logic [15:0]      range_raw;
    logic [7:0]       inten;
    logic [31:0]      tus;
    logic [14:0]      va;
  } ret_t;

  typedef struct {
    logic [19:0] x;
    logic [19:0] y;
    logic [19:0] z;
    logic [7:0]  inten;
    logic [41:0] ts;
  } pt_t;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [5:0]   cfg_wdata_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [111:0] m_axis_tdata;

  lidar_return_to_xyz dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  ret_t        pending_q[$];
  pt_t         point_q[$];
  ret_t        cur;
  logic [14:0] angle_tab [MAX_LASERS];
  logic [5:0]  lasers;
  bit          calm;
  int          fails;

  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  function automatic void octant(input longint unsigned r,
                                 output longint unsigned s, output longint unsigned c);
    longint unsigned sk [4] = '{72, 42, 20, 6};
    longint unsigned ck [5] = '{90, 56, 30, 12, 2};
    longint unsigned x, x2, u;
    x  = (r * 64'd191900981 + 64'd512) >> 10;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    u  = ONE_Q30;
    for (int i = 0; i < 4; i++) u = ONE_Q30 - ((x2 * u) >> 30) / sk[i];
    s = (x * u) >> 30;
    u = ONE_Q30;
    for (int i = 0; i < 5; i++) u = ONE_Q30 - ((x2 * u) >> 30) / ck[i];
    c = u;
  endfunction

  function automatic longint sat_q(input longint unsigned v);
    return (v > ONE_Q30) ? longint'(ONE_Q30) : longint'(v);
  endfunction

  function automatic void sincos(input int unsigned a, output longint sn, output longint cs);
    int unsigned     q, r;
    longint unsigned s0, c0;
    longint          s, c;
    q = a / 9000;
    r = a % 9000;
    if (r <= 4500) begin
      octant(r, s0, c0);
      s = sat_q(s0); c = sat_q(c0);
    end else begin
      octant(9000 - r, s0, c0);
      s = sat_q(c0); c = sat_q(s0);
    end
    case (q)
      0: begin sn = s;  cs = c;  end
      1: begin sn = c;  cs = -s; end
      2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endfunction

  function automatic longint round_q30(input longint a, input longint b);
    bit              neg;
    longint unsigned m;
    neg = (a < 0) != (b < 0);
    m = ((a < 0 ? -a : a) * (b < 0 ? -b : b) + (64'd1 << 29)) >> 30;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [19:0] axis_pos(input longint d8, input longint t1, input longint t2);
    longint v;
    v = round_q30(d8, round_q30(t1, t2));
    if (v > 524280) v = 524280;
    if (v < -524280) v = -524280;
    return v[19:0];
  endfunction

  function automatic void project_return(input ret_t it);
    int              laser, v;
    longint          sa, ca, sv, cv, d8;
    longint unsigned ts;
    pt_t             p;
    if (it.op == OP_WRITE) begin
      angle_tab[it.ch] = it.va;
      return;
    end
    if (it.range_raw == 0) return;
    laser = (lasers > 0) ? int'(it.ch) % int'(lasers) : 0;
    laser = laser % MAX_LASERS;
    v = $signed(angle_tab[laser]);
    if (v < 0) v += 36000;
    sincos(int'(it.az) % 36000, sa, ca);
    sincos(v % 36000, sv, cv);
    d8 = longint'(it.range_raw) * 8;
    p.x = axis_pos(d8, cv, sa);
    p.y = axis_pos(d8, cv, ca);
    p.z = axis_pos(d8, sv, ONE_Q30);
    p.inten = it.inten;
    ts = longint'(it.tus) * 1000 + longint'(it.blk) * 55296
         + longint'(it.pkt) * 12 * 55296;
    p.ts = ts[41:0];
    point_q.push_back(p);
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) project_return(cur);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 28)) begin
          cur = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= cur.op;
          s_axis_tdata  <= {4'b0, cur.va, cur.tus, cur.inten, cur.range_raw, cur.az,
                            cur.ch, cur.blk, cur.pkt};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (point_q.size() == 0) begin
          $error("unexpected point transfer %h", m_axis_tdata);
          fails++;
        end else begin
          pt_t e;
          e = point_q.pop_front();
          if (m_axis_tdata[19:0] !== e.x) begin
            $error("x_pos exp %h got %h", e.x, m_axis_tdata[19:0]); fails++;
          end
          if (m_axis_tdata[39:20] !== e.y) begin
            $error("y_pos exp %h got %h", e.y, m_axis_tdata[39:20]); fails++;
          end
          if (m_axis_tdata[59:40] !== e.z) begin
            $error("z_pos exp %h got %h", e.z, m_axis_tdata[59:40]); fails++;
          end
          if (m_axis_tdata[67:60] !== e.inten) begin
            $error("point_intensity exp %h got %h", e.inten, m_axis_tdata[67:60]); fails++;
          end
          if (m_axis_tdata[109:68] !== e.ts) begin
            $error("timestamp_ns exp %h got %h", e.ts, m_axis_tdata[109:68]); fails++;
          end
        end
      end
      m_axis_tready <= calm || ($urandom_range(99) >= 28);
    end
  end

  function automatic ret_t mk(input op_e op, input int ch, input int az, input int range_raw,
                              input int va);
    ret_t r;
    r.op        = op;
    r.pkt       = 12'($urandom);
    r.blk       = 4'($urandom);
    r.ch        = 5'(ch);
    r.az        = 16'(az);
    r.range_raw = 16'(range_raw);
    r.inten     = 8'($urandom);
    r.tus       = $urandom;
    r.va        = 15'(va);
    return r;
  endfunction

  function automatic ret_t rand_return();
    int k, az, rng;
    k = $urandom_range(99);
    az = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(35999);
    rng = ($urandom_range(19) == 0) ? 0 : $urandom_range(65535, 1);
    if (k < 10)
      return mk(OP_WRITE, $urandom_range(31), az, rng,
                ($urandom_range(3) == 0) ? $urandom_range(32767)
                                         : (int'($urandom_range(18000)) - 9000));
    return mk(OP_CONVERT, $urandom_range(31), az, rng, $urandom_range(32767));
  endfunction

  task automatic drain();
    while (pending_q.size() > 0 || s_axis_tvalid || point_q.size() > 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic set_lasers(input logic [5:0] n);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= n;
    lasers = n;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    int          vas [8] = '{9000, -9000, 0, 4500, -4500, 16383, -16384, 4501};
    int          azs [8] = '{0, 4500, 9000, 18000, 27000, 35999, 65535, 4501};
    logic [5:0]  lc_set [6] = '{6'd32, 6'd1, 6'd63, 6'd0, 6'd7, 6'd16};
    ret_t        r;
    fails = 0;
    calm = 1'b0;
    lasers = 6'd16;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < MAX_LASERS; i++)
      pending_q.push_back(mk(OP_WRITE, i, 0, 0, vas[i % 8]));
    for (int i = 0; i < 8; i++)
      pending_q.push_back(mk(OP_CONVERT, i, azs[i], (i == 0) ? 65535 : 1000 + i, 0));
    r = mk(OP_CONVERT, 5, 1234, 0, 0);
    pending_q.push_back(r);
    r = mk(OP_CONVERT, 31, 35999, 65535, 32767);
    r.pkt = 12'hFFF; r.blk = 4'hF; r.tus = 32'hFFFF_FFFF; r.inten = 8'hFF;
    pending_q.push_back(r);
    r = mk(OP_CONVERT, 0, 0, 1, 0);
    r.pkt = '0; r.blk = '0; r.tus = '0; r.inten = '0;
    pending_q.push_back(r);
    drain();

    foreach (lc_set[p]) begin
      set_lasers(lc_set[p]);
      calm = (p == 2);
      for (int i = 0; i < 315; i++) pending_q.push_back(rand_return());
      drain();
    end

    if (fails == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
`default_nettype wire
